// File: design/assert_macros.svh
// Assertion macros shared by the cylinder support mapping design.
// Depends on clk_i and rst_ni being present in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("csm assertion failed");

// Check that a condition never holds.
`define CSM_NEVER(lbl, cond) `CSM_ASSERT(lbl, !(cond))

`endif

// File: design/csm_pkg.sv
// Types, constants and helper functions of the cylinder support mapping.
// No dependencies.
package csm_pkg;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned CapPoints = 8;
  localparam logic [15:0] DiagQ16 = 16'd51472;

  typedef enum logic [1:0] {
    KindPoint = 2'd0,
    KindEdge  = 2'd1,
    KindCap   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CapZero,
    CapPosR,
    CapNegR,
    CapPosD,
    CapNegD
  } cap_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic        xneg;
    logic        zneg;
    logic        ypos;
  } item_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] enc_sat(input logic ovf, input logic [31:0] q,
                                          input logic neg);
    if (neg) begin
      enc_sat = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
    end else begin
      enc_sat = (ovf || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
    end
  endfunction

  function automatic cap_e cap_x(input logic [2:0] idx);
    unique case (idx)
      3'd0, 3'd4: cap_x = CapZero;
      3'd1, 3'd3: cap_x = CapPosD;
      3'd2:       cap_x = CapPosR;
      3'd6:       cap_x = CapNegR;
      default:    cap_x = CapNegD;
    endcase
  endfunction

  function automatic cap_e cap_z(input logic [2:0] idx);
    unique case (idx)
      3'd2, 3'd6: cap_z = CapZero;
      3'd0:       cap_z = CapPosR;
      3'd4:       cap_z = CapNegR;
      3'd1, 3'd7: cap_z = CapPosD;
      default:    cap_z = CapNegD;
    endcase
  endfunction

  function automatic logic [31:0] cap_val(input cap_e c, input logic [30:0] r,
                                          input logic [30:0] rd);
    unique case (c)
      CapPosR: cap_val = {1'b0, r};
      CapNegR: cap_val = 32'd0 - {1'b0, r};
      CapPosD: cap_val = {1'b0, rd};
      CapNegD: cap_val = 32'd0 - {1'b0, rd};
      default: cap_val = 32'd0;
    endcase
  endfunction

endpackage

// File: design/csm_fifo.sv
// Short item queue between the front and the back of the support mapping.
// Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module csm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  csm_pkg::item_t wdata_i,
  input  logic          pop_i,
  output csm_pkg::item_t rdata_o,
  output logic          full_o,
  output logic          avail_o
);
  import csm_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  item_t             mem_q [FifoDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(FifoDepth));
  assign avail_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  `CSM_NEVER(a_no_overflow, push_i && full_o && !pop_i)
  `CSM_NEVER(a_no_underflow, pop_i && !avail_o)
  `CSM_ASSERT(a_cnt_bound, cnt_q <= CntW'(FifoDepth))

endmodule

// File: design/csm_front.sv
// Front end: accepts commands and classifies the direction vector.
// Depends on csm_pkg.
module csm_front (
  input  logic          start_i,
  input  logic          full_i,
  input  logic          mode_i,
  input  logic [31:0]   dir_x_i,
  input  logic [31:0]   dir_y_i,
  input  logic [31:0]   dir_z_i,
  output logic          busy_o,
  output logic          push_o,
  output csm_pkg::item_t item_o
);
  import csm_pkg::*;

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    item_o.mode = mode_i;
    item_o.ax   = mag32(dir_x_i);
    item_o.ay   = mag32(dir_y_i);
    item_o.az   = mag32(dir_z_i);
    item_o.xneg = dir_x_i[31];
    item_o.zneg = dir_z_i[31];
    item_o.ypos = !dir_y_i[31] && (dir_y_i != 32'd0);
  end

endmodule

// File: design/csm_back.sv
// Back end: square root, side test, scaling divisions and point emission.
// Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module csm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  csm_pkg::item_t item_i,
  input  logic [30:0]   radius_i,
  input  logic [30:0]   height_i,
  output logic          pop_o,
  output logic          valid_o,
  output logic [31:0]   point_x_o,
  output logic [31:0]   point_y_o,
  output logic [31:0]   point_z_o,
  output logic [1:0]    point_kind_o,
  output logic          last_o
);
  import csm_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SSqx, SSqz, SRoot, SSideA, SSideB, SDecide, SLoad, SPrep, SDiv, SEmit
  } state_e;

  state_e      state_q;
  item_t       item_q;
  logic [63:0] sq_q;
  logic [33:0] rrem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic [62:0] lhs_q, rhs_q, num_q;
  logic [30:0] rd_q;
  logic [31:0] rem_q, quo_q, px_q, pz_q;
  logic        ovf_q, sel_q, flip_q;
  logic [2:0]  ecnt_q, elast_q;
  kind_e       kind_q;

  logic [63:0] sqx, sqz;
  logic [33:0] rrem_sh, trial;
  logic        rge;
  logic [62:0] prod_oh, prod_ry, prod_rc;
  logic [47:0] rdp;
  logic [32:0] drem_sh;
  logic        dge;
  logic [31:0] num_lo, quo_fin, enc_val, ycap;
  logic [29:0] hh;

  assign pop_o   = (state_q == SIdle) && avail_i;
  assign sqx     = item_q.ax * item_q.ax;
  assign sqz     = item_q.az * item_q.az;
  assign rrem_sh = {rrem_q[31:0], sq_q[63:62]};
  assign trial   = {root_q, 2'b01};
  assign rge     = (rrem_sh >= trial);
  assign prod_oh = root_q * height_i;
  assign prod_ry = radius_i * item_q.ay;
  assign prod_rc = radius_i * (sel_q ? item_q.az : item_q.ax);
  assign rdp     = 48'(radius_i) * 48'(DiagQ16) + 48'd32768;
  assign num_lo  = num_q[31:0];
  assign drem_sh = {rem_q, num_lo[cnt_q]};
  assign dge     = (drem_sh >= {1'b0, root_q});
  assign quo_fin = {quo_q[30:0], dge};
  assign enc_val = enc_sat(ovf_q, quo_fin, (sel_q ? item_q.zneg : item_q.xneg) ^ flip_q);
  assign hh      = height_i[30:1];
  assign ycap    = item_q.ypos ? {2'b00, hh} : (32'd0 - {2'b00, hh});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      valid_o <= 1'b0;
      last_o  <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (avail_i) begin
            item_q  <= item_i;
            state_q <= SSqx;
          end
        end
        SSqx: begin
          sq_q    <= sqx;
          state_q <= SSqz;
        end
        SSqz: begin
          sq_q    <= sq_q + sqz;
          rrem_q  <= '0;
          root_q  <= '0;
          cnt_q   <= 5'd31;
          state_q <= SRoot;
        end
        SRoot: begin
          rrem_q <= rge ? (rrem_sh - trial) : rrem_sh;
          root_q <= {root_q[30:0], rge};
          sq_q   <= {sq_q[61:0], 2'b00};
          cnt_q  <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            state_q <= SSideA;
          end
        end
        SSideA: begin
          lhs_q   <= prod_oh;
          state_q <= SSideB;
        end
        SSideB: begin
          rhs_q   <= prod_ry;
          state_q <= SDecide;
        end
        SDecide: begin
          rd_q   <= rdp[46:16];
          ecnt_q <= '0;
          sel_q  <= 1'b0;
          if (!item_q.mode) begin
            kind_q  <= KindPoint;
            elast_q <= 3'd0;
            flip_q  <= 1'b0;
            if (root_q == 32'd0) begin
              px_q    <= '0;
              pz_q    <= '0;
              state_q <= SEmit;
            end else begin
              state_q <= SLoad;
            end
          end else if ({1'b0, lhs_q} > {rhs_q, 1'b0}) begin
            kind_q  <= KindEdge;
            elast_q <= 3'd1;
            flip_q  <= 1'b1;
            state_q <= SLoad;
          end else begin
            kind_q  <= KindCap;
            elast_q <= 3'(CapPoints - 1);
            state_q <= SEmit;
          end
        end
        SLoad: begin
          num_q   <= prod_rc;
          state_q <= SPrep;
        end
        SPrep: begin
          ovf_q   <= ({1'b0, num_q[62:32]} >= root_q);
          rem_q   <= {1'b0, num_q[62:32]};
          quo_q   <= '0;
          cnt_q   <= 5'd31;
          state_q <= SDiv;
        end
        SDiv: begin
          rem_q <= dge ? 32'(drem_sh - {1'b0, root_q}) : drem_sh[31:0];
          quo_q <= quo_fin;
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            if (!sel_q) begin
              px_q    <= enc_val;
              sel_q   <= 1'b1;
              state_q <= SLoad;
            end else begin
              pz_q    <= enc_val;
              state_q <= SEmit;
            end
          end
        end
        SEmit: begin
          valid_o      <= 1'b1;
          last_o       <= (ecnt_q == elast_q);
          point_kind_o <= kind_q;
          ecnt_q       <= ecnt_q + 3'd1;
          unique case (kind_q)
            KindCap: begin
              point_x_o <= cap_val(cap_x(ecnt_q), radius_i, rd_q);
              point_z_o <= cap_val(cap_z(ecnt_q), radius_i, rd_q);
              point_y_o <= ycap;
            end
            KindEdge: begin
              point_x_o <= px_q;
              point_z_o <= pz_q;
              point_y_o <= (ecnt_q == 3'd0) ? {2'b00, hh} : (32'd0 - {2'b00, hh});
            end
            default: begin
              point_x_o <= px_q;
              point_z_o <= pz_q;
              point_y_o <= ycap;
            end
          endcase
          if (ecnt_q == elast_q) begin
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `CSM_ASSERT(a_gap_after_last, (valid_o && last_o) |=> !valid_o)
  `CSM_ASSERT(a_pop_only_idle, pop_o |=> (state_q == SSqx))
  `CSM_ASSERT(a_last_has_valid, last_o |-> (valid_o && $past(state_q) == SEmit))

endmodule

// File: design/cylinder_support_mapping.sv
// Support mapping of a Y-axis cylinder centered at the origin, Q16.16 fixed point.
// Pulse start_i while busy_o is low to hand in a command; points come out on
// valid_o, one per cycle, and must be taken as they appear since the receiver
// cannot stall. The back end runs a 32-step square root per command and, for
// side edges and support points with nonzero horizontal direction, two 32-step
// divisions. The next command is taken from the queue in the same cycle as the
// last point shows on valid_o. A two-entry queue lets new commands be taken
// while the back end works. Radius and height are written through cfg_we_i;
// the user must write them only while no command is in flight, which the
// block itself does not enforce.
// Depends on csm_pkg, csm_front, csm_fifo and csm_back.
module cylinder_support_mapping (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [31:0] dir_x_i,
  input  logic [31:0] dir_y_i,
  input  logic [31:0] dir_z_i,
  output logic        valid_o,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  output logic [31:0] point_z_o,
  output logic [1:0]  point_kind_o,
  output logic        last_o
);
  import csm_pkg::*;

  logic [30:0] radius_q, height_q;
  logic        push, pop, full, avail;
  item_t       fin, fout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 31'd65536;
      height_q <= 31'd131072;
    end else if (cfg_we_i) begin
      if (cfg_idx_i) begin
        height_q <= cfg_wdata_i;
      end else begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  csm_front u_front (
    .start_i (start_i),
    .full_i  (full),
    .mode_i  (mode_i),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .busy_o  (busy_o),
    .push_o  (push),
    .item_o  (fin)
  );

  csm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fin),
    .pop_i   (pop),
    .rdata_o (fout),
    .full_o  (full),
    .avail_o (avail)
  );

  csm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .item_i       (fout),
    .radius_i     (radius_q),
    .height_i     (height_q),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .point_z_o    (point_z_o),
    .point_kind_o (point_kind_o),
    .last_o       (last_o)
  );

endmodule

// File: tb/sv/cylinder_support_mapping_tb.sv
// Self-checking testbench for cylinder_support_mapping: drives commands, predicts every point.
// Depends on csm_pkg and the cylinder_support_mapping RTL.
`timescale 1ns / 100ps

module cylinder_support_mapping_tb;
  import csm_pkg::*;

  typedef struct {
    logic        mode;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
  } cmd_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    kind_e       kind;
    logic        last;
  } point_t;

  localparam int unsigned WatchdogLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        mode_i = 1'b0;
  logic [31:0] dir_x_i = '0;
  logic [31:0] dir_y_i = '0;
  logic [31:0] dir_z_i = '0;
  logic        valid_o;
  logic [31:0] point_x_o;
  logic [31:0] point_y_o;
  logic [31:0] point_z_o;
  logic [1:0]  point_kind_o;
  logic        last_o;

  cmd_t        pending_cmds[$];
  point_t      expected_points[$];
  logic [30:0] radius_q = 31'd65536;
  logic [30:0] height_q = 31'd131072;
  int unsigned idle_pct = 25;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  cylinder_support_mapping DUT (.*);

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs32(input logic [31:0] v);
    return {32'd0, (v[31] ? (~v + 32'd1) : v)};
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] m, input logic neg);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'd0 - m[31:0];
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic logic [31:0] scale_dir(input logic [31:0] c, input logic [63:0] o,
                                            input logic flip);
    logic [63:0] q;
    q = ({33'd0, radius_q} * abs32(c)) / o;
    return sat32(q, c[31] ^ flip);
  endfunction

  function automatic logic [31:0] cap_coord(input int s, input logic [63:0] rd);
    logic [63:0] m;
    m = (s == 0) ? 64'd0 : ((s == 1 || s == -1) ? {33'd0, radius_q} : rd);
    return sat32(m, s < 0);
  endfunction

  task automatic predict_points(input cmd_t c);
    int          cx[8] = '{0, 2, 1, 2, 0, -2, -1, -2};
    int          cz[8] = '{1, 2, 0, -2, -1, -2, 0, 2};
    logic [63:0] o;
    logic [63:0] hh;
    logic [63:0] rd;
    logic        ypos;
    logic [31:0] ycap;
    point_t      p;
    o = isqrt64(abs32(c.dx) * abs32(c.dx) + abs32(c.dz) * abs32(c.dz));
    hh = {33'd0, height_q} >> 1;
    ypos = !c.dy[31] && c.dy != 0;
    ycap = sat32(hh, !ypos);
    if (c.mode == 1'b0) begin
      p.x = (o > 0) ? scale_dir(c.dx, o, 1'b0) : 32'd0;
      p.z = (o > 0) ? scale_dir(c.dz, o, 1'b0) : 32'd0;
      p.y = ycap;
      p.kind = KindPoint;
      p.last = 1'b1;
      expected_points.push_back(p);
    end else if (o * {33'd0, height_q} > 2 * ({33'd0, radius_q} * abs32(c.dy))) begin
      p.x = scale_dir(c.dx, o, 1'b1);
      p.z = scale_dir(c.dz, o, 1'b1);
      p.kind = KindEdge;
      p.y = sat32(hh, 1'b0);
      p.last = 1'b0;
      expected_points.push_back(p);
      p.y = sat32(hh, 1'b1);
      p.last = 1'b1;
      expected_points.push_back(p);
    end else begin
      rd = ({33'd0, radius_q} * 64'd51472 + 64'd32768) >> 16;
      for (int i = 0; i < 8; i++) begin
        p.x = cap_coord(cx[i], rd);
        p.z = cap_coord(cz[i], rd);
        p.y = ycap;
        p.kind = KindCap;
        p.last = (i == 7);
        expected_points.push_back(p);
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    logic   accepted;
    logic   drive_next;
    cmd_t   c;
    accepted = start_i && !busy_o;
    if (accepted) begin
      c.mode = mode_i;
      c.dx = dir_x_i;
      c.dy = dir_y_i;
      c.dz = dir_z_i;
      predict_points(c);
    end
    if (rst_ni && (accepted || !start_i)) begin
      drive_next = pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct;
      if (drive_next) begin
        c = pending_cmds.pop_front();
        mode_i <= c.mode;
        dir_x_i <= c.dx;
        dir_y_i <= c.dy;
        dir_z_i <= c.dz;
      end
      start_i <= drive_next;
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    point_t e;
    if (valid_o) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%h y=%h z=%h", point_x_o, point_y_o, point_z_o);
      end else begin
        e = expected_points.pop_front();
        if (point_x_o !== e.x || point_y_o !== e.y || point_z_o !== e.z ||
            point_kind_o !== e.kind || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h k%0d l%0d got %h %h %h k%0d l%0d",
                     e.x, e.y, e.z, e.kind, e.last, point_x_o, point_y_o, point_z_o,
                     point_kind_o, last_o);
        end
      end
    end
    if (valid_o || (start_i && !busy_o)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rand_dir();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom_range(4) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: v = $urandom_range(2) == 0 ? 32'd0 : ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
      2, 3: v = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rand_reg();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(31'h0010_0000));
      2: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
      default: return 31'($urandom_range(31'h0004_0000, 31'h0000_4000));
    endcase
  endfunction

  task automatic add_cmd(input logic m, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] z);
    cmd_t c;
    c.mode = m;
    c.dx = x;
    c.dy = y;
    c.dz = z;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start_i);
    @(posedge clk_i);
    wait (expected_points.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx) height_q = val;
    else radius_q = val;
  endtask

  initial begin
    logic [30:0] regs[6][2];
    regs = '{'{31'd65536, 31'd131072}, '{31'h7FFF_FFFF, 31'h7FFF_FFFF}, '{31'd0, 31'd0},
             '{31'd0, 31'h7FFF_FFFF}, '{31'h7FFF_FFFF, 31'd1}, '{31'd1, 31'd3}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_cmd(0, 0, 0, 0);
    add_cmd(1, 0, 0, 0);
    add_cmd(1, 0, 32'h0001_0000, 0);
    add_cmd(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_cmd(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_cmd(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cmd(1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
    add_cmd(1, 32'h0001_0000, 32'd0, 32'hFFFF_0000);
    add_cmd(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1);
    add_cmd(0, 32'd1, 32'hFFFF_FFFF, 32'd0);
    add_cmd(0, 32'd0, 32'd1, 32'h8000_0000);
    add_cmd(1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    add_cmd(1, 32'h0001_0000, 32'h0000_FFFF, 32'd0);
    add_cmd(0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    add_cmd(1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    add_cmd(0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    write_reg(0, 31'd1);
    write_reg(1, 31'd1);
    add_cmd(0, 32'd1, 32'd5, 32'd0);
    add_cmd(1, 32'd3, 32'd1, 32'd4);
    add_cmd(1, 32'd1, 32'd1, 32'd0);
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      idle_pct = (ph < 3) ? 25 : ((ph < 6) ? 60 : 0);
      if (ph < 6) begin
        write_reg(0, regs[ph][0]);
        write_reg(1, regs[ph][1]);
      end else begin
        write_reg(0, rand_reg());
        write_reg(1, rand_reg());
      end
      for (int i = 0; i < 33; i++)
        add_cmd($urandom_range(1), rand_dir(), rand_dir(), rand_dir());
    end
    drain();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
